// ----- hw/rtl/rhtt_pkg.sv -----
// Shared types, codes and sizes for the rectangle hit test table.
`timescale 1ns / 1ps
package rhtt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CSR_ADDR_W  = 3;

   // register index of the frozen bit, taken from paddr[CSR_ADDR_W-1:2]
   localparam logic [CSR_ADDR_W-3:0] REG_FROZEN = '0;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_HIT    = 2'd3
   } cmd_type;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_EMPTY_RECT = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_MISS       = 3'd3;
   localparam logic [2:0] ST_FROZEN     = 3'd4;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_REMOVE,
      SEQ_SEARCH
   } seq_state_type;

   typedef struct packed {
      logic [7:0]         kind;
      logic [15:0]        x;
      logic [15:0]        y;
      logic [15:0]        w;
      logic [15:0]        h;
      logic signed [31:0] payload;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } ram_req_type;

endpackage

// ----- hw/rtl/rhtt_table_ram.sv -----
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps
module rhtt_table_ram
   import rhtt_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output entry_type   rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rhtt_ctrl.sv -----
// Command sequencer with the shared entry compare unit and the result registers.
`timescale 1ns / 1ps
module rhtt_ctrl
   import rhtt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_entry_kind,
   input  logic [15:0]        req_rect_x,
   input  logic [15:0]        req_rect_y,
   input  logic [15:0]        req_rect_w,
   input  logic [15:0]        req_rect_h,
   input  logic signed [31:0] req_entry_payload,
   input  logic [15:0]        req_point_x,
   input  logic [15:0]        req_point_y,
   input  logic               frozen,
   output ram_req_type        ram_req,
   input  entry_type          ram_rd_data,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic               rsp_hit_found,
   output entry_type          rsp_entry,
   output logic [CNT_W-1:0]   rsp_entry_count,
   output logic [31:0]        rsp_empty_query_total,
   output logic               rsp_full_warning
);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic             pend_ff, pend_in;
   logic [31:0]      empty_total_ff, empty_total_in;
   logic             warned_ff, warned_in;
   logic [7:0]       kind_ff, kind_in;
   logic [15:0]      px_ff, px_in;
   logic [15:0]      py_ff, py_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   entry_type        rsp_entry_ff, rsp_entry_in;
   logic             rsp_warn_ff, rsp_warn_in;

   logic [16:0]      right_edge;
   logic [16:0]      bottom_edge;
   logic             point_inside;
   logic             issue;
   logic [CNT_W-1:0] scan_dec;
   cmd_type          cmd;

   // shared compare unit: edges at 17 bits so nothing wraps
   always_comb begin
      right_edge   = {1'b0, ram_rd_data.x} + {1'b0, ram_rd_data.w};
      bottom_edge  = {1'b0, ram_rd_data.y} + {1'b0, ram_rd_data.h};
      point_inside = (px_ff >= ram_rd_data.x) && ({1'b0, px_ff} < right_edge) &&
                     (py_ff >= ram_rd_data.y) && ({1'b0, py_ff} < bottom_edge);
   end

   assign cmd      = cmd_type'(req_command);
   assign scan_dec = scan_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         fill_ff        <= '0;
         empty_total_ff <= '0;
         warned_ff      <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         empty_total_ff <= empty_total_in;
         warned_ff      <= warned_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      wr_ff         <= wr_in;
      kind_ff       <= kind_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_warn_ff   <= rsp_warn_in;
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      scan_in        = scan_ff;
      wr_in          = wr_ff;
      pend_in        = 1'b0;
      empty_total_in = empty_total_ff;
      warned_in      = warned_ff;
      kind_in        = kind_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_found_in   = 1'b0;
      rsp_entry_in   = '0;
      rsp_warn_in    = 1'b0;
      ram_req        = '0;
      issue          = 1'b0;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               kind_in = req_entry_kind;
               px_in   = req_point_x;
               py_in   = req_point_y;
               unique case (cmd)
                  CMD_CLEAR: begin
                     fill_in      = '0;
                     warned_in    = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (req_rect_w == '0 || req_rect_h == '0) begin
                        rsp_status_in = ST_EMPTY_RECT;
                     end else if (fill_ff >= CNT_W'(TABLE_DEPTH)) begin
                        rsp_status_in = ST_FULL;
                        rsp_warn_in   = !warned_ff;
                        warned_in     = 1'b1;
                     end else begin
                        ram_req.wr_en           = 1'b1;
                        ram_req.wr_addr         = fill_ff[IDX_W-1:0];
                        ram_req.wr_data.kind    = req_entry_kind;
                        ram_req.wr_data.x       = req_rect_x;
                        ram_req.wr_data.y       = req_rect_y;
                        ram_req.wr_data.w       = req_rect_w;
                        ram_req.wr_data.h       = req_rect_h;
                        ram_req.wr_data.payload = req_entry_payload;
                        fill_in                 = fill_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = SEQ_REMOVE;
                        scan_in  = '0;
                        wr_in    = '0;
                     end
                  end
                  CMD_HIT: begin
                     if (frozen) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FROZEN;
                     end else if (fill_ff == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = ST_MISS;
                        empty_total_in = empty_total_ff + 32'd1;
                     end else begin
                        state_in = SEQ_SEARCH;
                        scan_in  = fill_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end

         SEQ_REMOVE: begin
            // read oldest first, write survivors back at the compacted index
            issue = (scan_ff != fill_ff);
            if (issue) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = scan_ff[IDX_W-1:0];
               scan_in         = scan_ff + CNT_W'(1);
            end
            pend_in = issue;
            if (pend_ff && ram_rd_data.kind != kind_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = wr_ff[IDX_W-1:0];
               ram_req.wr_data = ram_rd_data;
               wr_in           = wr_ff + CNT_W'(1);
            end
            if (!issue && !pend_ff) begin
               fill_in      = wr_ff;
               rsp_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end

         SEQ_SEARCH: begin
            // newest first; stop on the first entry that holds the point
            if (pend_ff && point_inside) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_entry_in = ram_rd_data;
               state_in     = SEQ_IDLE;
            end else begin
               issue = (scan_ff != '0);
               if (issue) begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = scan_dec[IDX_W-1:0];
                  scan_in         = scan_dec;
               end
               pend_in = issue;
               if (!issue && !pend_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_MISS;
                  state_in      = SEQ_IDLE;
               end
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign busy                  = (state_ff != SEQ_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_hit_found         = rsp_found_ff;
   assign rsp_entry             = rsp_entry_ff;
   assign rsp_entry_count       = fill_ff;
   assign rsp_empty_query_total = empty_total_ff;
   assign rsp_full_warning      = rsp_warn_ff;

endmodule

// ----- hw/rtl/rectangle_hit_test_table_unit.sv -----
// Top level: configuration port, command sequencer and entry memory.
`timescale 1ns / 1ps
// Tagged rectangle table with last-wins hit test. A command is taken when start
// is high and busy is low. Its single result appears on the rsp_ ports for exactly
// one cycle, marked by rsp_valid, and cannot be held off. The following answer in
// the cycle after the command is taken and never raise busy: clear, add, a frozen
// hit, a hit on an empty table and remove kind on an empty table. Remove kind on a
// nonempty table holds busy while it compacts the table; a hit search holds busy
// until the first entry examined (newest first) that holds the point, or until all
// entries are examined on a miss. In both cases the result shows as busy falls. Both
// walk the entry memory one entry per cycle; the search tests each entry in the
// shared compare unit. The frozen bit sits at byte address 0 of the APB port.
module rectangle_hit_test_table_unit
   import rhtt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [7:0]            req_entry_kind,
   input  logic [15:0]           req_rect_x,
   input  logic [15:0]           req_rect_y,
   input  logic [15:0]           req_rect_w,
   input  logic [15:0]           req_rect_h,
   input  logic signed [31:0]    req_entry_payload,
   input  logic [15:0]           req_point_x,
   input  logic [15:0]           req_point_y,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic                  rsp_hit_found,
   output logic [7:0]            rsp_hit_kind,
   output logic [15:0]           rsp_hit_x,
   output logic [15:0]           rsp_hit_y,
   output logic [15:0]           rsp_hit_w,
   output logic [15:0]           rsp_hit_h,
   output logic signed [31:0]    rsp_hit_payload,
   output logic [6:0]            rsp_entry_count,
   output logic [31:0]           rsp_empty_query_total,
   output logic                  rsp_full_warning,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic        frozen_ff, frozen_in;
   logic        csr_write;
   ram_req_type ram_req;
   entry_type   ram_rd_data;
   entry_type   rsp_entry;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      frozen_in = frozen_ff;
      if (csr_write && paddr[CSR_ADDR_W-1:2] == REG_FROZEN) begin
         frozen_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_ff <= 1'b0;
      end else begin
         frozen_ff <= frozen_in;
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_FROZEN) ? {31'd0, frozen_ff} : 32'd0;

   rhtt_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_entry_kind        (req_entry_kind),
      .req_rect_x            (req_rect_x),
      .req_rect_y            (req_rect_y),
      .req_rect_w            (req_rect_w),
      .req_rect_h            (req_rect_h),
      .req_entry_payload     (req_entry_payload),
      .req_point_x           (req_point_x),
      .req_point_y           (req_point_y),
      .frozen                (frozen_ff),
      .ram_req               (ram_req),
      .ram_rd_data           (ram_rd_data),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_hit_found         (rsp_hit_found),
      .rsp_entry             (rsp_entry),
      .rsp_entry_count       (rsp_entry_count),
      .rsp_empty_query_total (rsp_empty_query_total),
      .rsp_full_warning      (rsp_full_warning)
   );

   rhtt_table_ram u_table_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   assign rsp_hit_kind    = rsp_entry.kind;
   assign rsp_hit_x       = rsp_entry.x;
   assign rsp_hit_y       = rsp_entry.y;
   assign rsp_hit_w       = rsp_entry.w;
   assign rsp_hit_h       = rsp_entry.h;
   assign rsp_hit_payload = rsp_entry.payload;

endmodule

// ----- hw/rtl/rhtt_checker.sv -----
// Port-level checks for the rectangle hit test table, bound to the top level.
`timescale 1ns / 1ps
module rhtt_checker
   import rhtt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [2:0]         rsp_status,
   input logic               rsp_hit_found,
   input logic [7:0]         rsp_hit_kind,
   input logic [15:0]        rsp_hit_x,
   input logic [15:0]        rsp_hit_y,
   input logic [15:0]        rsp_hit_w,
   input logic [15:0]        rsp_hit_h,
   input logic signed [31:0] rsp_hit_payload,
   input logic [6:0]         rsp_entry_count,
   input logic               rsp_full_warning
);

   // every accepted transaction either answers next cycle or holds busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted transaction produced neither result nor busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_found) |-> (rsp_status == ST_OK && rsp_hit_w != '0 &&
                                        rsp_hit_h != '0))
      else $error("hit reported with bad status or empty rectangle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit_found) |-> (rsp_hit_kind == '0 && rsp_hit_x == '0 &&
         rsp_hit_y == '0 && rsp_hit_w == '0 && rsp_hit_h == '0 && rsp_hit_payload == '0))
      else $error("hit fields not zero without a hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= 7'(TABLE_DEPTH)))
      else $error("entry count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_full_warning) |-> (rsp_status == ST_FULL &&
                                           rsp_entry_count == 7'(TABLE_DEPTH)))
      else $error("full warning without a full drop");

endmodule

bind rectangle_hit_test_table_unit rhtt_checker u_rhtt_checker (.*);

// ----- tb/tb_rectangle_hit_test_table_unit.sv -----
// Self-checking testbench for the rectangle hit test table: directed script, then random phases.
`timescale 1ns / 1ps
module tb_rectangle_hit_test_table_unit;
   import rhtt_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   typedef struct {
      cmd_type            cmd;
      bit                 frz;
      logic [7:0]         kind;
      logic [15:0]        rx, ry, rw, rh;
      logic signed [31:0] pay;
      logic [15:0]        px, py;
      bit                 typed;
      logic [2:0]         t_status;
      logic [6:0]         t_count;
   } cmd_item_type;

   typedef struct {
      logic [2:0]         status;
      logic               found;
      logic [7:0]         kind;
      logic [15:0]        x, y, w, h;
      logic signed [31:0] payload;
      logic [6:0]         count;
      logic [31:0]        total;
      logic               warn;
   } result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_command;
   logic [7:0]            req_entry_kind;
   logic [15:0]           req_rect_x, req_rect_y, req_rect_w, req_rect_h;
   logic signed [31:0]    req_entry_payload;
   logic [15:0]           req_point_x, req_point_y;
   logic                  rsp_valid;
   logic [2:0]            rsp_status;
   logic                  rsp_hit_found;
   logic [7:0]            rsp_hit_kind;
   logic [15:0]           rsp_hit_x, rsp_hit_y, rsp_hit_w, rsp_hit_h;
   logic signed [31:0]    rsp_hit_payload;
   logic [6:0]            rsp_entry_count;
   logic [31:0]           rsp_empty_query_total;
   logic                  rsp_full_warning;
   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   // table mirror
   entry_type    slots [TABLE_DEPTH];
   int           fill;
   logic [31:0]  empty_hits;
   bit           warned;
   bit           frozen_now;

   result_type   awaited [$];
   cmd_item_type script [$];
   int           errors;
   int           results_seen;
   int           idle_cycles;
   int           burst_left;
   bit           no_idle;

   rectangle_hit_test_table_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_entry_kind(req_entry_kind),
      .req_rect_x(req_rect_x), .req_rect_y(req_rect_y),
      .req_rect_w(req_rect_w), .req_rect_h(req_rect_h),
      .req_entry_payload(req_entry_payload),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_hit_found(rsp_hit_found),
      .rsp_hit_kind(rsp_hit_kind), .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y),
      .rsp_hit_w(rsp_hit_w), .rsp_hit_h(rsp_hit_h), .rsp_hit_payload(rsp_hit_payload),
      .rsp_entry_count(rsp_entry_count), .rsp_empty_query_total(rsp_empty_query_total),
      .rsp_full_warning(rsp_full_warning),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      if (errors <= 60)
         $display("ERROR: %s got %0h expected %0h (result %0d)", what, got, want, results_seen);
   endtask

   // Apply one command to the mirrored table and return the result it must produce.
   function automatic result_type table_result(input cmd_item_type it);
      result_type r;
      int         i, keep, hit_at;
      int         px, py;
      r = '{status: ST_OK, found: 1'b0, kind: '0, x: '0, y: '0, w: '0, h: '0,
            payload: '0, count: '0, total: '0, warn: 1'b0};
      hit_at = -1;
      px = it.px;
      py = it.py;
      case (it.cmd)
         CMD_CLEAR: begin
            fill = 0;
            warned = 1'b0;
         end
         CMD_ADD: begin
            if (it.rw == 0 || it.rh == 0) begin
               r.status = ST_EMPTY_RECT;
            end else if (fill >= TABLE_DEPTH) begin
               r.status = ST_FULL;
               r.warn = !warned;
               warned = 1'b1;
            end else begin
               slots[fill] = '{kind: it.kind, x: it.rx, y: it.ry, w: it.rw, h: it.rh,
                               payload: it.pay};
               fill++;
            end
         end
         CMD_REMOVE: begin
            keep = 0;
            for (i = 0; i < fill; i++) begin
               if (slots[i].kind != it.kind) begin
                  slots[keep] = slots[i];
                  keep++;
               end
            end
            fill = keep;
         end
         default: begin
            if (frozen_now) begin
               r.status = ST_FROZEN;
            end else if (fill == 0) begin
               empty_hits++;
               r.status = ST_MISS;
            end else begin
               // newest first; right and bottom edges open, computed without wrap
               for (i = fill - 1; i >= 0 && hit_at < 0; i--) begin
                  if (px >= int'(slots[i].x) && px < int'(slots[i].x) + int'(slots[i].w) &&
                      py >= int'(slots[i].y) && py < int'(slots[i].y) + int'(slots[i].h))
                     hit_at = i;
               end
               if (hit_at < 0) begin
                  r.status = ST_MISS;
               end else begin
                  r.found = 1'b1;
                  r.kind = slots[hit_at].kind;
                  r.x = slots[hit_at].x;
                  r.y = slots[hit_at].y;
                  r.w = slots[hit_at].w;
                  r.h = slots[hit_at].h;
                  r.payload = slots[hit_at].payload;
               end
            end
         end
      endcase
      r.count = 7'(fill);
      r.total = empty_hits;
      return r;
   endfunction

   function automatic void row(input cmd_type c, input bit f, input logic [7:0] k,
                               input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] w, input logic [15:0] h,
                               input logic signed [31:0] p,
                               input logic [15:0] qx, input logic [15:0] qy,
                               input bit ty, input logic [2:0] st, input logic [6:0] cnt);
      cmd_item_type it;
      it.cmd = c;
      it.frz = f;
      it.kind = k;
      it.rx = x;
      it.ry = y;
      it.rw = w;
      it.rh = h;
      it.pay = p;
      it.px = qx;
      it.py = qy;
      it.typed = ty;
      it.t_status = st;
      it.t_count = cnt;
      script.push_back(it);
   endfunction

   function automatic cmd_item_type random_command();
      cmd_item_type it;
      int           r, mode;
      it.frz = frozen_now;
      it.typed = 1'b0;
      it.t_status = ST_OK;
      it.t_count = '0;
      it.kind = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      it.pay = $urandom;
      r = $urandom_range(0, 99);
      // an occasional run of adds drives the table into the full case
      if (burst_left > 0) begin
         burst_left--;
         r = 10;
      end else if ($urandom_range(0, 199) == 0) begin
         burst_left = 70;
      end
      if (r < 2)
         it.cmd = CMD_CLEAR;
      else if (r < 48)
         it.cmd = CMD_ADD;
      else if (r < 56)
         it.cmd = CMD_REMOVE;
      else
         it.cmd = CMD_HIT;
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
         it.rx = 16'($urandom_range(0, 63));
         it.ry = 16'($urandom_range(0, 63));
         it.rw = 16'($urandom_range(1, 32));
         it.rh = 16'($urandom_range(1, 32));
         it.px = 16'($urandom_range(0, 95));
         it.py = 16'($urandom_range(0, 95));
         if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1) == 1)
               it.rw = '0;
            else
               it.rh = '0;
         end
      end else if (mode == 7) begin
         it.rx = 16'(65535 - $urandom_range(0, 31));
         it.ry = 16'(65535 - $urandom_range(0, 31));
         it.rw = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
         it.rh = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
         it.px = 16'(65535 - $urandom_range(0, 47));
         it.py = 16'(65535 - $urandom_range(0, 47));
      end else begin
         it.rx = 16'($urandom);
         it.ry = 16'($urandom);
         it.rw = 16'($urandom);
         it.rh = 16'($urandom);
         it.px = 16'($urandom);
         it.py = 16'($urandom);
      end
      return it;
   endfunction

   task automatic issue(input cmd_item_type it);
      result_type want;
      bit         taken;
      int         gap, r;
      req_command <= it.cmd;
      req_entry_kind <= it.kind;
      req_rect_x <= it.rx;
      req_rect_y <= it.ry;
      req_rect_w <= it.rw;
      req_rect_h <= it.rh;
      req_entry_payload <= it.pay;
      req_point_x <= it.px;
      req_point_y <= it.py;
      start <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (!busy) begin
            want = table_result(it);
            if (it.typed) begin
               want.status = it.t_status;
               want.count = it.t_count;
               want.warn = 1'b0;
            end
            awaited.push_back(want);
            taken = 1'b1;
         end
         @(posedge clock);
      end
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         gap = 0;
      else if (r < 90)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(4, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain the block, then write the frozen bit and read it back.
   task automatic write_frozen(input logic v);
      logic [31:0] word;
      start <= 1'b0;
      do @(negedge clock); while (awaited.size() != 0 || busy);
      @(posedge clock);
      repeat (4) @(posedge clock);
      word = $urandom;
      word[0] = v;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_FROZEN, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      frozen_now = v;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      if (prdata[0] !== v)
         report("frozen readback", prdata[0], v);
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(negedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (awaited.size() == 0) begin
            report("result with none awaited, status", rsp_status, 0);
         end else begin
            want = awaited.pop_front();
            if (rsp_status !== want.status) report("status", rsp_status, want.status);
            if (rsp_hit_found !== want.found) report("hit_found", rsp_hit_found, want.found);
            if (rsp_hit_kind !== want.kind) report("hit_kind", rsp_hit_kind, want.kind);
            if (rsp_hit_x !== want.x) report("hit_x", rsp_hit_x, want.x);
            if (rsp_hit_y !== want.y) report("hit_y", rsp_hit_y, want.y);
            if (rsp_hit_w !== want.w) report("hit_w", rsp_hit_w, want.w);
            if (rsp_hit_h !== want.h) report("hit_h", rsp_hit_h, want.h);
            if (rsp_hit_payload !== want.payload)
               report("hit_payload", rsp_hit_payload, want.payload);
            if (rsp_entry_count !== want.count)
               report("entry_count", rsp_entry_count, want.count);
            if (rsp_empty_query_total !== want.total)
               report("empty_query_total", rsp_empty_query_total, want.total);
            if (rsp_full_warning !== want.warn)
               report("full_warning", rsp_full_warning, want.warn);
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int ph, n, len;
      errors = 0;
      results_seen = 0;
      idle_cycles = 0;
      burst_left = 0;
      no_idle = 1'b0;
      fill = 0;
      empty_hits = '0;
      warned = 1'b0;
      frozen_now = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_CLEAR;
      req_entry_kind <= '0;
      req_rect_x <= '0;
      req_rect_y <= '0;
      req_rect_w <= '0;
      req_rect_h <= '0;
      req_entry_payload <= '0;
      req_point_x <= '0;
      req_point_y <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hit on empty table, zero-size drops, edge rectangles, overlap, removal, frozen
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 1, ST_MISS, 0);
      row(CMD_ADD, 0, 8'h11, 5, 5, 0, 7, 32'sd9, 0, 0, 1, ST_EMPTY_RECT, 0);
      row(CMD_ADD, 0, 8'h22, 5, 5, 7, 0, 32'sd9, 0, 0, 1, ST_EMPTY_RECT, 0);
      row(CMD_ADD, 0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh80000000,
          0, 0, 1, ST_OK, 1);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, ST_OK, 0);
      row(CMD_ADD, 0, 8'h00, 0, 0, 1, 1, 32'sh7FFFFFFF, 0, 0, 1, ST_OK, 2);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0, ST_OK, 0);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'h0001, 16'h0000, 1, ST_MISS, 2);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'h0000, 16'h0001, 1, ST_MISS, 2);
      row(CMD_ADD, 0, 8'h55, 0, 0, 16'hFFFF, 16'hFFFF, -32'sd1, 0, 0, 1, ST_OK, 3);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0, ST_OK, 0);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, ST_OK, 0);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'hFFFE, 16'hFFFE, 0, ST_OK, 0);
      row(CMD_REMOVE, 0, 8'h55, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 2);
      row(CMD_REMOVE, 0, 8'h12, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 2);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0, ST_OK, 0);
      row(CMD_CLEAR, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'hFFFF, 16'h0000, 1, ST_MISS, 0);
      row(CMD_HIT, 1, 8'h00, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 1, ST_FROZEN, 0);
      row(CMD_ADD, 1, 8'hAA, 100, 200, 3, 4, 32'sh12345678, 0, 0, 1, ST_OK, 1);
      row(CMD_HIT, 1, 8'h00, 0, 0, 0, 0, 0, 16'd101, 16'd201, 1, ST_FROZEN, 1);
      row(CMD_HIT, 0, 8'h00, 0, 0, 0, 0, 0, 16'd102, 16'd203, 0, ST_OK, 0);
      row(CMD_REMOVE, 0, 8'hAA, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0);

      write_frozen(1'b0);
      foreach (script[i]) begin
         if (script[i].frz != frozen_now)
            write_frozen(script[i].frz);
         issue(script[i]);
      end

      // alternate open and frozen phases
      for (ph = 0; ph < 5; ph++) begin
         write_frozen(1'(ph % 2));
         len = (ph % 2 == 1) ? 75 : 293;
         for (n = 0; n < len; n++) begin
            if (n % 50 == 0)
               no_idle = ($urandom_range(0, 3) == 0);
            issue(random_command());
         end
      end

      start <= 1'b0;
      while (awaited.size() != 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
      if (awaited.size() != 0)
         report("results never delivered", awaited.size(), 0);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
